FILE: rtl/yrgb_pkg.sv
// ---------------------------------------------------------------------------
// yrgb_pkg
// Shared types, constants and rounding helpers for the semi-planar 4:2:0
// to packed three-channel pixel converter.
// ---------------------------------------------------------------------------
package yrgb_pkg;

  // Geometry of one request
  localparam int unsigned PIXELS       = 8;
  localparam int unsigned CHROMA_PAIRS = 4;
  localparam int unsigned CHANNELS     = 3;
  localparam int unsigned WORD_W       = 64;

  // Widths of the datapath: products fit 18 bits signed, channel terms 12
  localparam int unsigned PROD_W = 18;
  localparam int unsigned TERM_W = 12;

  // Fixed-point coefficients, scale 1/256
  localparam logic signed [PROD_W-1:0] CHROMA_BIAS = 18'sd128;
  localparam logic signed [PROD_W-1:0] COEF_C0_U   = 18'sd104;
  localparam logic signed [PROD_W-1:0] COEF_C1_V   = 18'sd89;
  localparam logic signed [PROD_W-1:0] COEF_C1_U   = 18'sd183;
  localparam logic signed [PROD_W-1:0] COEF_C2_V   = 18'sd199;
  localparam logic signed [PROD_W-1:0] ROUND_UP    = 18'sd255;

  typedef logic signed [TERM_W-1:0] term_t;

  // Chroma contributions shared by the two pixels of one pair
  typedef struct packed {
    term_t c0;
    term_t c1;
    term_t c2;
  } chroma_terms_t;

  typedef struct packed {
    logic [WORD_W-1:0] luma_word;
    logic [WORD_W-1:0] chroma_word;
  } yrgb_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] rgb_word_low;
    logic [WORD_W-1:0] rgb_word_mid;
    logic [WORD_W-1:0] rgb_word_high;
  } yrgb_out_t;

  // Divide by 256, rounding toward zero
  function automatic logic signed [PROD_W-1:0] div256_trunc(
      input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] biased;
    biased = p + ROUND_UP;
    return p[PROD_W-1] ? (biased >>> 8) : (p >>> 8);
  endfunction

  // Divide by 256, rounding toward minus infinity
  function automatic logic signed [PROD_W-1:0] div256_floor(
      input logic signed [PROD_W-1:0] p);
    return p >>> 8;
  endfunction

endpackage

FILE: rtl/yrgb_chroma_lane.sv
// ---------------------------------------------------------------------------
// yrgb_chroma_lane
// One chroma pair: removes the bias, scales by the fixed-point coefficients
// and registers the three channel terms shared by two pixels.
// ---------------------------------------------------------------------------
module yrgb_chroma_lane
  import yrgb_pkg::*;
(
  input  logic          clk_i,
  input  logic          load_i,
  input  logic [7:0]    u_i,
  input  logic [7:0]    v_i,
  output chroma_terms_t terms_o
);

  logic signed [PROD_W-1:0] du, dv;
  logic signed [PROD_W-1:0] p_c0u, p_c1v, p_c1u, p_c2v;
  logic signed [PROD_W-1:0] t0, t1, t2;
  chroma_terms_t            terms_d, terms_q;

  // Center chroma and form the products
  always_comb begin
    du    = $signed({{(PROD_W-8){1'b0}}, u_i}) - CHROMA_BIAS;
    dv    = $signed({{(PROD_W-8){1'b0}}, v_i}) - CHROMA_BIAS;
    p_c0u = du * COEF_C0_U;
    p_c1v = dv * COEF_C1_V;
    p_c1u = du * COEF_C1_U;
    p_c2v = dv * COEF_C2_V;
    t0    = du + div256_trunc(p_c0u);
    t1    = -div256_floor(p_c1v) - div256_trunc(p_c1u);
    t2    = dv + div256_floor(p_c2v);
    terms_d.c0 = t0[TERM_W-1:0];
    terms_d.c1 = t1[TERM_W-1:0];
    terms_d.c2 = t2[TERM_W-1:0];
  end

  // Hold the terms while the stage is stalled
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      terms_q <= terms_d;
    end
  end

  assign terms_o = terms_q;

endmodule

FILE: rtl/yrgb_pixel_lane.sv
// ---------------------------------------------------------------------------
// yrgb_pixel_lane
// One pixel: adds luma to the shared chroma terms and clamps each channel
// to the byte range.
// ---------------------------------------------------------------------------
module yrgb_pixel_lane
  import yrgb_pkg::*;
(
  input  logic [7:0]    luma_i,
  input  chroma_terms_t terms_i,
  output logic [7:0]    c0_o,
  output logic [7:0]    c1_o,
  output logic [7:0]    c2_o
);

  term_t y_ext;
  term_t s0, s1, s2;

  function automatic logic [7:0] clamp_byte(input term_t x);
    if (x[TERM_W-1]) begin
      return 8'd0;
    end else if (x > term_t'(255)) begin
      return 8'hFF;
    end
    return x[7:0];
  endfunction

  // Sum and saturate each channel
  always_comb begin
    y_ext = $signed({{(TERM_W-8){1'b0}}, luma_i});
    s0    = y_ext + terms_i.c0;
    s1    = y_ext + terms_i.c1;
    s2    = y_ext + terms_i.c2;
    c0_o  = clamp_byte(s0);
    c1_o  = clamp_byte(s1);
    c2_o  = clamp_byte(s2);
  end

endmodule

FILE: rtl/yuv420sp_to_rgb_8px_unit.sv
// ---------------------------------------------------------------------------
// yuv420sp_to_rgb_8px_unit
// Converts eight semi-planar 4:2:0 pixels per request into 24 packed bytes.
//
// Input channel: in_valid_i / in_stall_o carry one request of a luma word
// (eight Y bytes, pixel 0 in bits 7..0) and a chroma word (four U,V pairs,
// U in the even byte). Pair k serves pixels 2k and 2k+1.
// Output channel: out_valid_o / out_stall_i carry three 64-bit words holding
// output byte 3*p+c = channel c of pixel p, little-endian.
// Two register stages: the first stage, then the output register behind out_valid_o.
// Throughput: one request per cycle while the output is not stalled; four
// chroma lanes compute the shared terms in the first stage, eight pixel lanes
// add luma, clamp and pack into the output register in the second.
// A stalled output holds its word; the first stage still fills while empty, so
// two requests can sit in the block before in_stall_o rises.
// Reset empties both stages; no request is in flight afterward.
// ---------------------------------------------------------------------------
module yuv420sp_to_rgb_8px_unit
  import yrgb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  yrgb_in_t  in_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output yrgb_out_t out_o
);

  logic                        s1_valid_q, s1_valid_d;
  logic                        out_valid_q, out_valid_d;
  logic                        out_load, s1_load;
  logic [WORD_W-1:0]           luma_q;
  chroma_terms_t               terms [CHROMA_PAIRS];
  logic [8*PIXELS*CHANNELS-1:0] rgb_flat;
  yrgb_out_t                   out_d, out_q;

  // Stage control: each stage loads when it is empty or its content moves on
  always_comb begin
    out_load    = !out_valid_q || !out_stall_i;
    s1_load     = !s1_valid_q || out_load;
    in_stall_o  = !s1_load;
    s1_valid_d  = s1_load ? in_valid_i : s1_valid_q;
    out_valid_d = out_load ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Stage 1: register luma alongside the chroma lane terms
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      luma_q <= in_i.luma_word;
    end
  end

  for (genvar k = 0; k < CHROMA_PAIRS; k++) begin : g_chroma
    yrgb_chroma_lane u_chroma (
      .clk_i   (clk_i),
      .load_i  (s1_load),
      .u_i     (in_i.chroma_word[16*k +: 8]),
      .v_i     (in_i.chroma_word[16*k+8 +: 8]),
      .terms_o (terms[k])
    );
  end

  // Stage 2: pixel lanes write their bytes into the packed result
  for (genvar p = 0; p < PIXELS; p++) begin : g_pixel
    yrgb_pixel_lane u_pixel (
      .luma_i  (luma_q[8*p +: 8]),
      .terms_i (terms[p/2]),
      .c0_o    (rgb_flat[8*(CHANNELS*p)   +: 8]),
      .c1_o    (rgb_flat[8*(CHANNELS*p+1) +: 8]),
      .c2_o    (rgb_flat[8*(CHANNELS*p+2) +: 8])
    );
  end

  // Merge bytes into the three output words
  always_comb begin
    out_d.rgb_word_low  = rgb_flat[WORD_W-1:0];
    out_d.rgb_word_mid  = rgb_flat[2*WORD_W-1:WORD_W];
    out_d.rgb_word_high = rgb_flat[3*WORD_W-1:2*WORD_W];
  end

  always_ff @(posedge clk_i) begin
    if (out_load && s1_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Checks on stage control
  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> !in_stall_o)
    else $error("input stalled with empty first stage");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> s1_valid_q)
    else $error("accepted request lost in first stage");

  a_hold_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && out_stall_i) |=> (s1_valid_q && $stable(luma_q)))
    else $error("first stage changed while blocked");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && (!out_valid_q || !out_stall_i)) |=> out_valid_o)
    else $error("first stage content did not reach output");

endmodule
